// File: src/trimmed_mean_sample_filter_top_assert.svh
// Assertion macros shared by the checker.
`ifndef TRIMMED_MEAN_SAMPLE_FILTER_TOP_ASSERT_SVH
`define TRIMMED_MEAN_SAMPLE_FILTER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TMSF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TMSF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Same-cycle implication that is checked during reset as well.
`define TMSF_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: src/trimf_pkg.sv
package trimf_pkg;

  localparam int unsigned SAMPLES    = 20;
  localparam int unsigned CHANNELS   = 16;

  localparam int unsigned CH_W       = 4;
  localparam int unsigned SMP_W      = 12;
  localparam int unsigned SUM_W      = 17;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned DROP_W     = SMP_W + 2;
  localparam int unsigned MEAN_SHIFT = 4;
  localparam int unsigned SHIFTED_W  = SUM_W - MEAN_SHIFT;
  localparam int unsigned CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int unsigned IQ_DEPTH   = 4;
  localparam int unsigned IQ_PTR_W   = $clog2(IQ_DEPTH);
  localparam int unsigned IQ_CNT_W   = $clog2(IQ_DEPTH + 1);

  localparam int unsigned OQ_DEPTH   = 4;
  localparam int unsigned OQ_PTR_W   = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CNT_W   = $clog2(OQ_DEPTH + 1);

  localparam logic [SMP_W-1:0] MAX_CODE     = '1;
  localparam logic [CH_W:0]    CHANNEL_LIM  = (CH_W + 1)'(CHANNELS);
  localparam logic [CNT_W-1:0] SAMPLES_LIM  = CNT_W'(SAMPLES);

  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic [SMP_W-1:0] sample;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } iq_head_t;

  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic [SMP_W-1:0] mean;
  } result_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [SUM_W-1:0] sum;
    logic [SMP_W-1:0] smallest;
    logic [SMP_W-1:0] second_smallest;
    logic [SMP_W-1:0] largest;
    logic [SMP_W-1:0] second_largest;
  } chan_state_t;

  localparam chan_state_t CLEAR_STATE = '{
    cnt:             '0,
    sum:             '0,
    smallest:        MAX_CODE,
    second_smallest: MAX_CODE,
    largest:         '0,
    second_largest:  '0
  };

endpackage

// File: src/trimf_front.sv
module trimf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  trimf_pkg::item_t  item_i,
  output trimf_pkg::iq_head_t head_o,
  input  logic              take_i
);
  import trimf_pkg::*;

  item_t               mem_q [IQ_DEPTH];
  logic [IQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [IQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [IQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                accept, keep, deq;

  assign full   = (cnt_q == IQ_CNT_W'(IQ_DEPTH));
  assign accept = push && !full;
  // Drop items for channels that are not present.
  assign keep   = accept && ({1'b0, item_i.channel} < CHANNEL_LIM);
  assign deq    = take_i && (cnt_q != '0);

  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = keep ? wr_ptr_q + IQ_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = deq  ? rd_ptr_q + IQ_PTR_W'(1) : rd_ptr_q;
    case ({keep, deq})
      2'b10:   cnt_d = cnt_q + IQ_CNT_W'(1);
      2'b01:   cnt_d = cnt_q - IQ_CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (keep) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// File: src/trimf_back.sv
module trimf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  trimf_pkg::iq_head_t head_i,
  output logic                take_o,
  output logic                empty,
  input  logic                pop,
  output trimf_pkg::result_t  res_o
);
  import trimf_pkg::*;

  chan_state_t         state_q [CHANNELS];
  chan_state_t         cur, nxt;
  logic [CH_IDX_W-1:0] idx;
  logic [SMP_W-1:0]    x;
  logic                done, fire;

  logic                s2_valid_q;
  chan_state_t         s2_state_q;
  logic [CH_W-1:0]     s2_channel_q;
  logic [DROP_W-1:0]   drop;
  logic [SUM_W-1:0]    trimmed;
  logic [SHIFTED_W-1:0] shifted;
  result_t             s2_res;

  result_t             oq_mem_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] oq_wr_q, oq_rd_q;
  logic [OQ_CNT_W-1:0] oq_cnt_q, oq_cnt_d;
  logic [OQ_CNT_W:0]   oq_used;
  logic                deq;

  // Stage 1: per-channel read-modify-write.
  assign idx = head_i.item.channel[CH_IDX_W-1:0];
  assign x   = head_i.item.sample;
  assign cur = state_q[idx];

  // Hold stage 1 when the stage 2 register and the result queue are all spoken for.
  assign oq_used = {1'b0, oq_cnt_q} + {{OQ_CNT_W{1'b0}}, s2_valid_q};
  assign fire    = head_i.valid && (oq_used < (OQ_CNT_W + 1)'(OQ_DEPTH));
  assign take_o  = fire;

  always_comb begin
    nxt     = cur;
    nxt.sum = cur.sum + SUM_W'(x);
    nxt.cnt = cur.cnt + CNT_W'(1);
    if (x < cur.smallest) begin
      nxt.second_smallest = cur.smallest;
      nxt.smallest        = x;
    end else if (x < cur.second_smallest) begin
      nxt.second_smallest = x;
    end
    if (x > cur.largest) begin
      nxt.second_largest = cur.largest;
      nxt.largest        = x;
    end else if (x > cur.second_largest) begin
      nxt.second_largest = x;
    end
  end

  assign done = (nxt.cnt >= SAMPLES_LIM);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        state_q[i] <= CLEAR_STATE;
      end
    end else if (fire) begin
      state_q[idx] <= done ? CLEAR_STATE : nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= fire && done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && done) begin
      s2_state_q   <= nxt;
      s2_channel_q <= head_i.item.channel;
    end
  end

  // Stage 2: drop the four extremes, scale and saturate.
  always_comb begin
    drop = DROP_W'(s2_state_q.smallest) + DROP_W'(s2_state_q.second_smallest)
         + DROP_W'(s2_state_q.largest) + DROP_W'(s2_state_q.second_largest);
    trimmed = (s2_state_q.sum >= SUM_W'(drop)) ? s2_state_q.sum - SUM_W'(drop) : '0;
    shifted = trimmed[SUM_W-1:MEAN_SHIFT];
    s2_res.channel = s2_channel_q;
    s2_res.mean    = (shifted > SHIFTED_W'(MAX_CODE)) ? MAX_CODE : shifted[SMP_W-1:0];
  end

  // Result queue.
  assign empty = (oq_cnt_q == '0);
  assign deq   = pop && !empty;
  assign res_o = oq_mem_q[oq_rd_q];

  always_comb begin
    case ({s2_valid_q, deq})
      2'b10:   oq_cnt_d = oq_cnt_q + OQ_CNT_W'(1);
      2'b01:   oq_cnt_d = oq_cnt_q - OQ_CNT_W'(1);
      default: oq_cnt_d = oq_cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      if (s2_valid_q) begin
        oq_wr_q <= oq_wr_q + OQ_PTR_W'(1);
      end
      if (deq) begin
        oq_rd_q <= oq_rd_q + OQ_PTR_W'(1);
      end
      oq_cnt_q <= oq_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      oq_mem_q[oq_wr_q] <= s2_res;
    end
  end

endmodule

// File: src/trimmed_mean_sample_filter_top.sv
// Channel   Direction  Handshake        Payload
// input     in         push / full      channel_i[3:0], sample_i[11:0]
// result    out        empty / pop      result_channel_o[3:0], mean_o[11:0]
//
// One item per cycle while the result queue has room, set by the per-channel read-modify-write.
// A completed window's result is registered in stage 2, then queued in the result queue.
// Reset clears all channel state at once; the block takes items in the first cycle after it.
// A stalled result side backs up a 4-entry result queue, then a 4-entry item queue, then full.
// Items for a channel that is not present are taken and dropped.
module trimmed_mean_sample_filter_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic [trimf_pkg::CH_W-1:0]  channel_i,
  input  logic [trimf_pkg::SMP_W-1:0] sample_i,
  output logic                       empty,
  input  logic                       pop,
  output logic [trimf_pkg::CH_W-1:0]  result_channel_o,
  output logic [trimf_pkg::SMP_W-1:0] mean_o
);
  import trimf_pkg::*;

  item_t    item;
  iq_head_t head;
  logic     take;
  result_t  res;

  assign item.channel = channel_i;
  assign item.sample  = sample_i;

  trimf_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .item_i (item),
    .head_o (head),
    .take_i (take)
  );

  trimf_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .take_o (take),
    .empty  (empty),
    .pop    (pop),
    .res_o  (res)
  );

  assign result_channel_o = res.channel;
  assign mean_o           = res.mean;

endmodule

// File: src/trimf_checker.sv
`include "trimmed_mean_sample_filter_top_assert.svh"

module trimf_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       push,
  input logic                       full,
  input logic [trimf_pkg::CH_W-1:0]  channel_i,
  input logic [trimf_pkg::SMP_W-1:0] sample_i,
  input logic                       empty,
  input logic                       pop,
  input logic [trimf_pkg::CH_W-1:0]  result_channel_o,
  input logic [trimf_pkg::SMP_W-1:0] mean_o
);

  // No result may be offered while reset holds the block.
  `TMSF_ASSERT_RST(a_empty_in_reset, !rst_ni, empty, "result offered during reset")

  // The item queue fills only behind a backed-up result queue.
  `TMSF_ASSERT_IMP(a_full_needs_result, full, !empty, "item queue full with no result waiting")

  // Full can only rise after an item was taken.
  `TMSF_ASSERT_IMP(a_full_rise_on_push, $rose(full), $past(push), "full rose without a push")

  // A waiting result holds until popped.
  `TMSF_ASSERT_NXT(a_result_holds, !empty && !pop,
    !empty && $stable(result_channel_o) && $stable(mean_o), "waiting result changed")

endmodule

bind trimmed_mean_sample_filter_top trimf_checker u_trimf_checker (.*);
